// ----- rtl/rgb_pkg.sv -----
// shared constants and types for the run-length bit vector
package rgb_pkg;
    localparam int VectorBits = 1024;
    localparam int GroupBits  = 8;
    localparam int NGroups    = VectorBits / GroupBits;
    localparam int UsedBits   = NGroups * GroupBits;
    localparam int IdxW       = 10;
    localparam int AddrW      = $clog2(NGroups);
    localparam int CntW       = 8;
    localparam int TableDepth = 2 * NGroups;

    localparam logic OP_READ = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic start_read;
        logic start_set;
    } rgb_cmd_t;

    typedef struct packed {
        logic done;
        logic ready;
    } rgb_stat_t;
endpackage

// ----- rtl/rgb_ram.sv -----
// generic single-port-write ram with registered read
module rgb_ram #(
    parameter int Width = 8,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rgb_datapath.sv -----
// run table datapath: walks runs for reads, rebuilds the table into the other bank for sets
module rgb_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rgb_pkg::rgb_cmd_t         cmd,
    input  logic                      op,
    input  logic [rgb_pkg::IdxW-1:0]  idx,
    output rgb_pkg::rgb_stat_t        stat,
    output logic                      bit_out,
    output logic [rgb_pkg::CntW-1:0]  used_out,
    output logic [rgb_pkg::CntW-1:0]  peak_out
);
    localparam int AW = rgb_pkg::AddrW;
    localparam int GB = rgb_pkg::GroupBits;
    localparam int CW = rgb_pkg::CntW;
    localparam int PW = $clog2(GB);

    typedef enum logic [6:0] {
        D_INIT  = 7'b0000001,
        D_IDLE  = 7'b0000010,
        D_RADDR = 7'b0000100,
        D_RWAIT = 7'b0001000,
        D_RCHK  = 7'b0010000,
        D_SWALK = 7'b0100000,
        D_FIN   = 7'b1000000
    } dstate_t;

    dstate_t st_reg, st_next;
    // source read pointer, destination write pointer
    logic [AW:0] r_reg, r_next;
    logic [AW:0] w_reg, w_next;
    logic [AW:0] used_reg, used_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [AW+1:0] end_reg, end_next;
    logic [AW:0] g_reg;
    logic [PW-1:0] pos_reg;
    logic op_reg, bit_reg, bit_next;
    // bank holding the live table
    logic bank_reg, bank_next;
    // pending output run
    logic [GB-1:0] pp_reg, pp_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic have_reg, have_next;
    logic [AW:0] gpos_reg, gpos_next;

    logic we;
    logic [AW:0] waddr, raddr;
    logic [GB-1:0] wpat, rpat;
    logic [CW-1:0] wcnt, rcnt;

    rgb_ram #(.Width(GB), .Depth(rgb_pkg::TableDepth)) u_pat (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wpat), .raddr(raddr), .rdata(rpat));
    rgb_ram #(.Width(CW), .Depth(rgb_pkg::TableDepth)) u_cnt (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcnt), .raddr(raddr), .rdata(rcnt));

    assign raddr = {bank_reg, r_reg[AW-1:0]};

    // a source run is split into before, the target group, and after; pieces
    // stream through one merge stage. sub-step tracked by seg_reg.
    logic [1:0] seg_reg, seg_next;
    logic [GB-1:0] mpat;
    logic [CW-1:0] mcnt;
    logic mval;
    logic [AW+1:0] rend;
    logic [CW-1:0] before_c, after_c;
    logic hit;

    always_comb
    begin
        rend = end_reg + (AW+2)'(rcnt);
        hit = ((AW+2)'(g_reg) >= end_reg) && ((AW+2)'(g_reg) < rend);
        before_c = CW'((AW+2)'(g_reg) - end_reg);
        after_c = CW'(rend - (AW+2)'(g_reg) - (AW+2)'(1));
        mval = 1'b0;
        mpat = rpat;
        mcnt = rcnt;
        unique case (seg_reg)
            2'd0:
            begin
                mval = hit ? (before_c != '0) : 1'b1;
                mcnt = hit ? before_c : rcnt;
            end
            2'd1:
            begin
                mval = 1'b1;
                mpat = rpat | (GB'(1) << pos_reg);
                mcnt = CW'(1);
            end
            2'd2:
            begin
                mval = after_c != '0;
                mcnt = after_c;
            end
            default:
            begin
                mval = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        r_next = r_reg;
        w_next = w_reg;
        used_next = used_reg;
        peak_next = peak_reg;
        end_next = end_reg;
        bit_next = bit_reg;
        bank_next = bank_reg;
        pp_next = pp_reg;
        pc_next = pc_reg;
        have_next = have_reg;
        gpos_next = gpos_reg;
        seg_next = seg_reg;
        we = 1'b0;
        waddr = {~bank_reg, w_reg[AW-1:0]};
        wpat = pp_reg;
        wcnt = pc_reg;
        stat.done = 1'b0;
        stat.ready = st_reg == D_IDLE;
        unique case (st_reg)
            D_INIT:
            begin
                // entry zero: one all-zero run covering every group
                we = 1'b1;
                waddr = '0;
                wpat = '0;
                wcnt = CW'(rgb_pkg::NGroups);
                st_next = D_IDLE;
            end
            D_IDLE:
            begin
                r_next = '0;
                w_next = '0;
                end_next = '0;
                have_next = 1'b0;
                seg_next = 2'd0;
                if (cmd.start_read || cmd.start_set)
                begin
                    bit_next = 1'b0;
                    st_next = D_RADDR;
                end
            end
            D_RADDR:
            begin
                st_next = D_RWAIT;
            end
            D_RWAIT:
            begin
                st_next = op_reg ? D_SWALK : D_RCHK;
            end
            D_RCHK:
            begin
                if (hit || r_reg + 1'b1 >= used_reg)
                begin
                    bit_next = hit ? rpat[pos_reg] : 1'b0;
                    st_next = D_FIN;
                end
                else
                begin
                    end_next = rend;
                    r_next = r_reg + 1'b1;
                    st_next = D_RADDR;
                end
            end
            D_SWALK:
            begin
                // merge current piece into pending run; write out when it differs.
                // rebuilt runs go to the other bank, so reads are never disturbed
                if (mval)
                begin
                    if (have_reg && pp_reg == mpat)
                    begin
                        pc_next = pc_reg + mcnt;
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            we = 1'b1;
                            w_next = w_reg + 1'b1;
                        end
                        pp_next = mpat;
                        pc_next = mcnt;
                        have_next = 1'b1;
                    end
                end
                if (seg_reg == 2'd0 && !hit || seg_reg == 2'd2)
                begin
                    seg_next = 2'd0;
                    end_next = rend;
                    if (r_reg + 1'b1 >= used_reg)
                    begin
                        st_next = D_FIN;
                        gpos_next = '1;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                        st_next = D_RADDR;
                    end
                end
                else
                begin
                    seg_next = seg_reg + 2'd1;
                end
            end
            D_FIN:
            begin
                if (op_reg && gpos_reg[0])
                begin
                    we = 1'b1;
                    bank_next = ~bank_reg;
                    used_next = w_reg + 1'b1;
                    if (CW'(w_reg + 1'b1) > peak_reg)
                    begin
                        peak_next = CW'(w_reg + 1'b1);
                    end
                    gpos_next = '0;
                end
                else
                begin
                    stat.done = 1'b1;
                    st_next = D_IDLE;
                end
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= D_INIT;
            used_reg <= (AW+1)'(1);
            peak_reg <= '0;
            r_reg <= '0;
            w_reg <= '0;
            end_reg <= '0;
            have_reg <= 1'b0;
            seg_reg <= '0;
            gpos_reg <= '0;
            bit_reg <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            used_reg <= used_next;
            peak_reg <= peak_next;
            r_reg <= r_next;
            w_reg <= w_next;
            end_reg <= end_next;
            have_reg <= have_next;
            seg_reg <= seg_next;
            gpos_reg <= gpos_next;
            bit_reg <= bit_next;
            bank_reg <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= pp_next;
        pc_reg <= pc_next;
        if (st_reg == D_IDLE && (cmd.start_read || cmd.start_set))
        begin
            op_reg <= op;
            g_reg <= (AW+1)'(idx / GB);
            pos_reg <= PW'(GB - 1 - (idx % GB));
        end
    end

    assign bit_out = bit_reg & ~op_reg;
    assign used_out = CW'(used_reg);
    assign peak_out = peak_reg;
endmodule

// ----- rtl/rgb_ctrl.sv -----
// item controller: handshakes, range check, result register
module rgb_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [rgb_pkg::IdxW-1:0] bit_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     index_error,
    output rgb_pkg::rgb_cmd_t        cmd,
    input  rgb_pkg::rgb_stat_t       stat
);
    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_BUSY = 3'b010,
        C_OUT  = 3'b100
    } cstate_t;

    cstate_t st_reg, st_next;
    logic err_reg, err_next;
    logic oor;

    assign oor = 32'(bit_index) >= 32'(rgb_pkg::UsedBits);
    assign in_ready = (st_reg == C_IDLE) && stat.ready;
    assign out_valid = st_reg == C_OUT;
    assign index_error = err_reg;

    always_comb
    begin
        st_next = st_reg;
        err_next = err_reg;
        cmd.start_read = 1'b0;
        cmd.start_set = 1'b0;
        unique case (st_reg)
            C_IDLE:
            begin
                if (in_valid && stat.ready)
                begin
                    err_next = oor;
                    if (oor)
                    begin
                        st_next = C_OUT;
                    end
                    else
                    begin
                        cmd.start_read = opcode == rgb_pkg::OP_READ;
                        cmd.start_set = opcode == rgb_pkg::OP_SET;
                        st_next = C_BUSY;
                    end
                end
            end
            C_BUSY:
            begin
                if (stat.done)
                begin
                    st_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (out_ready)
                begin
                    st_next = C_IDLE;
                end
            end
            default:
            begin
                st_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE;
            err_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            err_reg <= err_next;
        end
    end
endmodule

// ----- rtl/rle_group_bitvector_core.sv -----
// top level of the run-length coded bit vector
// a read walks runs through D_RADDR, D_RWAIT and D_RCHK up to the one holding the bit
// a set walks every run through D_RADDR, D_RWAIT and D_SWALK, writing the other bank
// throughput: one item at a time; next beat taken the cycle after the result beat
// reset: vector is one all-zero run of 128 groups, peak cleared; the D_INIT state
// after reset writes that run before in_ready rises
module rle_group_bitvector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [rgb_pkg::IdxW-1:0]         bit_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             read_bit,
    output logic [rgb_pkg::CntW-1:0]         run_total,
    output logic [rgb_pkg::CntW-1:0]         peak_runs,
    output logic                             index_error
);
    rgb_pkg::rgb_cmd_t  cmd;
    rgb_pkg::rgb_stat_t stat;
    logic bit_w;

    rgb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .bit_index(bit_index), .out_valid(out_valid),
        .out_ready(out_ready), .index_error(index_error), .cmd(cmd), .stat(stat));

    rgb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .op(opcode), .idx(bit_index),
        .stat(stat), .bit_out(bit_w), .used_out(run_total), .peak_out(peak_runs));

    assign read_bit = bit_w & ~index_error;
endmodule
